// ===== rtl/pguf_pkg.sv =====
`timescale 1ns / 1ps
package pguf_pkg;

  localparam int GRID_MAX_DEF  = 64;
  localparam int GRID_RESET    = 64;
  localparam int OPEN_TOTAL_W  = 13;

  localparam logic [1:0] FN_OPEN   = 2'd0;
  localparam logic [1:0] FN_QUERY  = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [2:0] CAND_TOP    = 3'd0;
  localparam logic [2:0] CAND_BOTTOM = 3'd1;
  localparam logic [2:0] CAND_UP     = 3'd2;
  localparam logic [2:0] CAND_DOWN   = 3'd3;
  localparam logic [2:0] CAND_LEFT   = 3'd4;
  localparam logic [2:0] CAND_RIGHT  = 3'd5;

  typedef enum logic [3:0] {
    DP_NOP, DP_CFG, DP_CLR_START, DP_CLR_STEP, DP_LOAD, DP_RD_SELF, DP_SEL,
    DP_WR_OPEN, DP_FIND_START, DP_FIND_STEP, DP_RD_WA, DP_RD_WB, DP_LINK, DP_RESULT
  } dp_op_t;

  typedef enum logic [2:0] {
    NODE_A, NODE_B, NODE_ME, NODE_TOP, NODE_BOT
  } node_sel_t;

  typedef struct packed {
    dp_op_t     op;
    node_sel_t  node;
    logic [2:0] cand;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       err;
    logic       self_open;
    logic       link;
    logic       find_done;
    logic       same_root;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/pguf_datapath.sv =====
`timescale 1ns / 1ps
module pguf_datapath #(
  parameter int GRID_MAX = pguf_pkg::GRID_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pguf_pkg::dp_cmd_t cmd,
  output pguf_pkg::dp_stat_t stat,
  input  logic [6:0]        cfg_data,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_site_open,
  output logic              out_site_full,
  output logic              out_percolates,
  output logic [pguf_pkg::OPEN_TOTAL_W-1:0] out_open_total,
  output logic              out_range_error
);
  import pguf_pkg::*;

  localparam int SITE_CAP = GRID_MAX * GRID_MAX;
  localparam int NODE_CAP = SITE_CAP + 2;
  localparam int AW  = $clog2(NODE_CAP);
  localparam int NW  = $clog2(NODE_CAP + 1);
  localparam int SW  = (SITE_CAP > 1) ? $clog2(SITE_CAP) : 1;
  localparam int SDW = $clog2(GRID_MAX + 1);
  localparam int CW  = (SDW > 7) ? SDW : 7;
  localparam int TW  = $clog2(SITE_CAP + 1);
  localparam int PW  = CW * 2 + 1;
  localparam int SIDE_RST = (GRID_RESET > GRID_MAX) ? GRID_MAX : GRID_RESET;

  logic [NW-1:0] parent_mem [NODE_CAP];
  logic [NW-1:0] weight_mem [NODE_CAP];
  logic          open_mem   [SITE_CAP];

  logic [SDW-1:0] side;
  logic [AW-1:0]  nn, cnt, idx, me, a, b, x, ra, rb, rme, rtop, rbot;
  logic [1:0]     func;
  logic [6:0]     r, c;
  logic           err, self_open, cand_ok, cand_nb;
  logic [NW-1:0]  parent_q, weight_q, wa;
  logic           open_q;
  logic [TW-1:0]  tally;

  logic [CW-1:0]  side_w, r_w, c_w, in_r_w, in_c_w;
  logic [AW-1:0]  bot, p, sel_node, par_raddr, wt_raddr, nb_b, sel_a;
  logic [SW-1:0]  open_raddr;
  logic           nb_ok, nb_is_site, in_grid, find_done;
  logic [PW-1:0]  idx_full;
  logic [SDW-1:0] cfg_side;
  logic [NW-1:0]  wsum;

  assign side_w = CW'(side);
  assign r_w    = CW'(r);
  assign c_w    = CW'(c);
  assign in_r_w = CW'(in_row);
  assign in_c_w = CW'(in_col);
  assign bot    = AW'(nn + AW'(1));
  assign p      = parent_q[AW-1:0];
  assign wsum   = wa + weight_q;

  assign in_grid = (in_r_w >= CW'(1)) && (in_r_w <= side_w) &&
                   (in_c_w >= CW'(1)) && (in_c_w <= side_w);
  assign idx_full = PW'(in_r_w - CW'(1)) * PW'(side_w) + PW'(in_c_w - CW'(1));

  always_comb begin
    if (cfg_data == 7'd0) cfg_side = SDW'(1);
    else if (32'(cfg_data) > GRID_MAX) cfg_side = SDW'(GRID_MAX);
    else cfg_side = SDW'(cfg_data);
  end

  // Candidate links of an opened site.
  always_comb begin
    nb_ok = 1'b0;
    nb_is_site = 1'b1;
    sel_a = me;
    nb_b = me;
    case (cmd.cand)
      CAND_TOP:    begin nb_ok = (r_w == CW'(1)); nb_is_site = 1'b0; sel_a = '0; end
      CAND_BOTTOM: begin nb_ok = (r_w == side_w); nb_is_site = 1'b0; sel_a = bot; end
      CAND_UP:     begin nb_ok = (r_w > CW'(1)); nb_b = me - AW'(side); end
      CAND_DOWN:   begin nb_ok = (r_w < side_w); nb_b = me + AW'(side); end
      CAND_LEFT:   begin nb_ok = (c_w > CW'(1)); nb_b = me - AW'(1); end
      CAND_RIGHT:  begin nb_ok = (c_w < side_w); nb_b = me + AW'(1); end
      default:     nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.node)
      NODE_A:   sel_node = a;
      NODE_B:   sel_node = b;
      NODE_ME:  sel_node = me;
      NODE_TOP: sel_node = '0;
      default:  sel_node = bot;
    endcase
  end

  assign find_done = (p == x) || (32'(p) >= NODE_CAP);

  always_comb begin
    par_raddr = p;
    if (cmd.op == DP_FIND_START) par_raddr = sel_node;
    wt_raddr = (cmd.op == DP_RD_WB) ? rb : ra;
    open_raddr = (cmd.op == DP_SEL) ? SW'(nb_b - AW'(1)) : SW'(idx);
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    parent_q <= parent_mem[par_raddr];
    weight_q <= weight_mem[wt_raddr];
    open_q   <= open_mem[open_raddr];
    if (cmd.op == DP_CLR_STEP) begin
      parent_mem[cnt] <= NW'(cnt);
      weight_mem[cnt] <= NW'(1);
      if (32'(cnt) < SITE_CAP) open_mem[SW'(cnt)] <= 1'b0;
    end
    if (cmd.op == DP_WR_OPEN) open_mem[SW'(idx)] <= 1'b1;
    if (cmd.op == DP_LINK) begin
      if (wa < weight_q) begin
        parent_mem[ra] <= NW'(rb);
        weight_mem[rb] <= wsum;
      end else begin
        parent_mem[rb] <= NW'(ra);
        weight_mem[ra] <= wsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    nn <= AW'(side) * AW'(side);
    case (cmd.op)
      DP_CLR_START: begin cnt <= '0; tally <= '0; end
      DP_CFG:       begin cnt <= '0; tally <= '0; end
      DP_CLR_STEP:  cnt <= cnt + AW'(1);
      DP_LOAD: begin
        func <= in_func;
        r    <= in_row;
        c    <= in_col;
        err  <= ((in_func == FN_OPEN) || (in_func == FN_QUERY)) && !in_grid;
        idx  <= AW'(idx_full);
        me   <= AW'(idx_full) + AW'(1);
      end
      DP_RD_SELF: ;
      DP_SEL: begin
        a       <= sel_a;
        b       <= nb_is_site ? nb_b : me;
        cand_ok <= nb_ok;
        cand_nb <= nb_is_site;
      end
      DP_WR_OPEN:    tally <= tally + TW'(1);
      DP_FIND_START: x <= sel_node;
      DP_FIND_STEP: begin
        if (find_done) begin
          case (cmd.node)
            NODE_A:   ra <= x;
            NODE_B:   rb <= x;
            NODE_ME:  rme <= x;
            NODE_TOP: rtop <= x;
            default:  rbot <= x;
          endcase
        end else begin
          x <= p;
        end
      end
      DP_RD_WB: wa <= weight_q;
      default: ;
    endcase
    if (cmd.op == DP_RESULT) begin
      out_site_open   <= !err && (func == FN_QUERY || func == FN_OPEN) &&
                         (func == FN_OPEN || self_open);
      out_site_full   <= !err && (func == FN_QUERY || func == FN_OPEN) && (rme == rtop);
      out_percolates  <= (rtop == rbot);
      out_open_total  <= OPEN_TOTAL_W'(tally);
      out_range_error <= err;
    end
  end

  // self_open is sampled the cycle after the read of the site is issued.
  logic self_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      side      <= SDW'(SIDE_RST);
      out_valid <= 1'b0;
      self_pend <= 1'b0;
    end else begin
      if (cmd.op == DP_CFG) side <= cfg_side;
      self_pend <= (cmd.op == DP_RD_SELF);
      if (cmd.op == DP_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (self_pend) self_open <= open_q;
  end

  assign stat.func      = func;
  assign stat.err       = err;
  assign stat.self_open = open_q;
  assign stat.link      = cand_ok && (!cand_nb || open_q);
  assign stat.find_done = find_done;
  assign stat.same_root = (ra == rb);
  assign stat.clr_last  = (32'(cnt) == NODE_CAP - 1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/pguf_ctrl.sv =====
`timescale 1ns / 1ps
module pguf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               cfg_valid,
  output logic               in_ready,
  output logic               cfg_ready,
  input  pguf_pkg::dp_stat_t stat,
  output pguf_pkg::dp_cmd_t  cmd
);
  import pguf_pkg::*;

  typedef enum logic [4:0] {
    S_CLR_START, S_CLR, S_IDLE, S_DECODE, S_SELF, S_WR_OPEN, S_SEL, S_CHK,
    S_FA, S_FB_START, S_FB, S_CMP, S_RWB, S_LINK, S_NEXTK,
    S_FME_START, S_FME, S_FT_START, S_FT, S_FBOT_START, S_FBOT, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] k;
  logic       with_result;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.node = NODE_A;
    cmd.cand = k;
    unique case (state)
      S_CLR_START:  cmd.op = DP_CLR_START;
      S_CLR:        cmd.op = DP_CLR_STEP;
      S_IDLE: begin
        if (cfg_valid) cmd.op = DP_CFG;
        else if (in_valid) cmd.op = DP_LOAD;
      end
      S_DECODE: begin
        if (stat.func == FN_CLEAR) cmd.op = DP_CLR_START;
        else if (!stat.err && (stat.func == FN_OPEN || stat.func == FN_QUERY))
          cmd.op = DP_RD_SELF;
      end
      S_SELF:       cmd.op = DP_NOP;
      S_WR_OPEN:    cmd.op = DP_WR_OPEN;
      S_SEL:        cmd.op = DP_SEL;
      S_CHK: begin
        if (stat.link) begin cmd.op = DP_FIND_START; cmd.node = NODE_A; end
      end
      S_FA:         begin cmd.op = DP_FIND_STEP;  cmd.node = NODE_A; end
      S_FB_START:   begin cmd.op = DP_FIND_START; cmd.node = NODE_B; end
      S_FB:         begin cmd.op = DP_FIND_STEP;  cmd.node = NODE_B; end
      S_CMP:        if (!stat.same_root) cmd.op = DP_RD_WA;
      S_RWB:        cmd.op = DP_RD_WB;
      S_LINK:       cmd.op = DP_LINK;
      S_NEXTK:      cmd.op = DP_NOP;
      S_FME_START:  begin cmd.op = DP_FIND_START; cmd.node = NODE_ME; end
      S_FME:        begin cmd.op = DP_FIND_STEP;  cmd.node = NODE_ME; end
      S_FT_START:   begin cmd.op = DP_FIND_START; cmd.node = NODE_TOP; end
      S_FT:         begin cmd.op = DP_FIND_STEP;  cmd.node = NODE_TOP; end
      S_FBOT_START: begin cmd.op = DP_FIND_START; cmd.node = NODE_BOT; end
      S_FBOT:       begin cmd.op = DP_FIND_STEP;  cmd.node = NODE_BOT; end
      S_DONE:       if (stat.out_free) cmd.op = DP_RESULT;
      default:      cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR_START;
      k           <= CAND_TOP;
      with_result <= 1'b0;
    end else begin
      unique case (state)
        S_CLR_START: state <= S_CLR;
        S_CLR: if (stat.clr_last) state <= with_result ? S_FT_START : S_IDLE;
        S_IDLE: begin
          if (cfg_valid) begin
            with_result <= 1'b0;
            state <= S_CLR;
          end else if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (stat.func == FN_CLEAR) begin
            with_result <= 1'b1;
            state <= S_CLR;
          end else if (!stat.err && (stat.func == FN_OPEN || stat.func == FN_QUERY)) begin
            state <= S_SELF;
          end else begin
            state <= S_FT_START;
          end
        end
        S_SELF: state <= (stat.func == FN_OPEN && !stat.self_open) ? S_WR_OPEN : S_FME_START;
        S_WR_OPEN: begin k <= CAND_TOP; state <= S_SEL; end
        S_SEL: state <= S_CHK;
        S_CHK: state <= stat.link ? S_FA : S_NEXTK;
        S_FA: if (stat.find_done) state <= S_FB_START;
        S_FB_START: state <= S_FB;
        S_FB: if (stat.find_done) state <= S_CMP;
        S_CMP: state <= stat.same_root ? S_NEXTK : S_RWB;
        S_RWB: state <= S_LINK;
        S_LINK: state <= S_NEXTK;
        S_NEXTK: begin
          if (k == CAND_RIGHT) state <= S_FME_START;
          else begin k <= k + 3'd1; state <= S_SEL; end
        end
        S_FME_START: state <= S_FME;
        S_FME: if (stat.find_done) state <= S_FT_START;
        S_FT_START: state <= S_FT;
        S_FT: if (stat.find_done) state <= S_FBOT_START;
        S_FBOT_START: state <= S_FBOT;
        S_FBOT: if (stat.find_done) state <= S_DONE;
        S_DONE: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/percolation_grid_union_find_core.sv =====
`timescale 1ns / 1ps
// Percolation grid with a weighted union-find forest (virtual top and bottom nodes).
// Requests arrive on the s_axis channel: s_tuser carries the function (open, query,
// clear) and s_tdata the one-based row and column. Every request produces exactly
// one result transaction on m_axis with the site flags, the percolation flag, the
// open-site count and a range error flag. The cfg channel writes the grid side
// length; a write also clears the grid.
// A query walks three roots (the site, the top and the bottom node), one tree level
// a cycle. An open also writes the site and checks each of its six candidate links;
// each candidate that is linked adds two root walks and, if the roots differ, reads
// of both root weights and the link write. One request is worked on at a time; the
// root walks all go through the single read port of the parent memory.
// A clear, a configuration write and reset each run a clearing pass over all
// GRID_MAX*GRID_MAX+2 node memory entries (4098 at the default), one entry a cycle,
// during which no request is taken; configuration writes are taken when idle.
// The result sits in an output register: while the receiver stalls, the next
// request is accepted and processed, and it waits only to deliver its own result.
module percolation_grid_union_find_core #(
  parameter int GRID_MAX = pguf_pkg::GRID_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row [6:0], col [13:7], zero [15:14]
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // site_open [0], site_full [1], percolates_now [2], open_total [15:3],
  // range_error [16], zero [23:17]
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // grid_size [6:0]
);
  import pguf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     site_open, site_full, percolates;
  logic     range_error;
  logic [OPEN_TOTAL_W-1:0] open_total;

  pguf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .cfg_valid (cfg_valid),
    .in_ready  (s_tready),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pguf_datapath #(.GRID_MAX(GRID_MAX)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_data        (cfg_data),
    .in_func         (s_tuser),
    .in_row          (s_tdata[6:0]),
    .in_col          (s_tdata[13:7]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_site_open   (site_open),
    .out_site_full   (site_full),
    .out_percolates  (percolates),
    .out_open_total  (open_total),
    .out_range_error (range_error)
  );

  assign m_tdata = {7'd0, range_error, open_total, percolates, site_full, site_open};

  // A request and a configuration write never complete in the same cycle.
  a_no_dual_accept: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready && cfg_valid && cfg_ready))
    else $error("request and configuration accepted together");

  // A full site is always an open one.
  a_full_is_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("site reported full but not open");

  // A range error reports neither site flag.
  a_err_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> !m_tdata[0] && !m_tdata[1])
    else $error("range error with site flags set");

  // The input side is never ready while a request is in flight.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request was accepted");

endmodule

// ===== tb/sv/pguf_checker.sv =====
`timescale 1ns / 1ps
module pguf_checker #(
  parameter int GRID_MAX = pguf_pkg::GRID_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import pguf_pkg::*;

  localparam int SITES = GRID_MAX * GRID_MAX;
  localparam int NODES = SITES + 2;

  typedef struct packed {
    logic        site_open;
    logic        site_full;
    logic        percolates;
    logic [12:0] open_total;
    logic        range_error;
  } site_report_t;

  bit       open_map [SITES];
  int       parent [NODES];
  int       weight [NODES];
  int       open_tally;
  int       side;
  site_report_t report_q[$];

  function automatic int clamp_side(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  task automatic wipe_grid();
    for (int k = 0; k < NODES; k++) begin
      parent[k] = k;
      weight[k] = 1;
    end
    for (int k = 0; k < SITES; k++) open_map[k] = 0;
    open_tally = 0;
  endtask

  function automatic int root_of(input int x);
    while (parent[x] != x) x = parent[x];
    return x;
  endfunction

  task automatic join_trees(input int a, input int b);
    int ra, rb;
    ra = root_of(a);
    rb = root_of(b);
    if (ra == rb) return;
    if (weight[ra] < weight[rb]) begin
      parent[ra] = rb;
      weight[rb] += weight[ra];
    end else begin
      parent[rb] = ra;
      weight[ra] += weight[rb];
    end
  endtask

  function automatic bit is_open(input int r, input int c);
    if (r < 1 || r > side || c < 1 || c > side) return 0;
    return open_map[(r - 1) * side + (c - 1)];
  endfunction

  task automatic link_if_open(input int me, input int r, input int c);
    if (is_open(r, c)) join_trees(me, (r - 1) * side + c);
  endtask

  // Apply one request to the shadow grid and return what the block must report.
  task automatic predict_site(input logic [1:0] fn, input int r, input int c,
                              output site_report_t rep);
    int me;
    rep = '0;
    if (fn == FN_CLEAR) begin
      wipe_grid();
    end else if (fn == FN_OPEN || fn == FN_QUERY) begin
      if (r < 1 || r > side || c < 1 || c > side) begin
        rep.range_error = 1;
      end else begin
        me = (r - 1) * side + c;
        if (fn == FN_OPEN && !is_open(r, c)) begin
          open_map[me - 1] = 1;
          if (r == 1) join_trees(0, me);
          if (r == side) join_trees(side * side + 1, me);
          link_if_open(me, r - 1, c);
          link_if_open(me, r + 1, c);
          link_if_open(me, r, c - 1);
          link_if_open(me, r, c + 1);
          open_tally++;
        end
        rep.site_open = is_open(r, c);
        rep.site_full = root_of(me) == root_of(0);
      end
    end
    rep.percolates = root_of(0) == root_of(side * side + 1);
    rep.open_total = open_tally[12:0];
  endtask

  assign pending = report_q.size();

  always @(posedge clk) begin
    site_report_t want, got;
    if (rst) begin
      side = GRID_RESET;
      fail_count = 0;
      result_count = 0;
      wipe_grid();
      report_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        got.site_open   = m_tdata[0];
        got.site_full   = m_tdata[1];
        got.percolates  = m_tdata[2];
        got.open_total  = m_tdata[15:3];
        got.range_error = m_tdata[16];
        if (report_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %h", m_tdata);
        end else begin
          want = report_q.pop_front();
          if (want != got || m_tdata[23:17] != 0) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected open=%0d full=%0d perc=%0d total=%0d err=%0d",
                       want.site_open, want.site_full, want.percolates, want.open_total,
                       want.range_error);
              $display("  got open=%0d full=%0d perc=%0d total=%0d err=%0d pad=%h",
                       got.site_open, got.site_full, got.percolates, got.open_total,
                       got.range_error, m_tdata[23:17]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        side = clamp_side(cfg_data);
        wipe_grid();
      end
      if (s_tvalid && s_tready) begin
        predict_site(s_tuser, s_tdata[6:0], s_tdata[13:7], want);
        report_q.push_back(want);
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pguf_pkg::*;

  // Generous bound on the whole run: clearing passes, stalls and deep root walks included.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_PER_PHASE = 180;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = 0;   // row [6:0], col [13:7], zero [15:14]
  logic [1:0]  s_tuser = 0;   // func [1:0]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [23:0] m_tdata;       // open, full, percolates, open_total [15:3], range_error [16]
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = 0;  // grid_size [6:0]

  int fail_count, pending, result_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int side = GRID_RESET;
  int items_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  percolation_grid_union_find_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pguf_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // The receiver stalls at random with the share of cycles set by the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request and hold it until the transaction completes. Valid stays
  // high into the next request unless the sender decides to idle for a while.
  task automatic send_request(input logic [1:0] fn, input logic [6:0] r, input logic [6:0] c);
    s_tvalid <= 1;
    s_tuser  <= fn;
    s_tdata  <= {2'b00, c, r};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has been delivered.
  task automatic drain_results();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_grid_size(input logic [6:0] v);
    drain_results();
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    cfg_writes++;
    side = (v == 0) ? 1 : (v > GRID_MAX_DEF) ? GRID_MAX_DEF : v;
  endtask

  // Mostly in-range opens and queries so that clusters grow and grids percolate;
  // the rest is out-of-range coordinates, the unused code and an occasional clear.
  task automatic random_request();
    int pick;
    logic [6:0] r, c, rr, rc;
    pick = $urandom_range(99);
    r = 7'($urandom_range(1, side));
    c = 7'($urandom_range(1, side));
    rr = 7'($urandom_range(127));
    rc = 7'($urandom_range(127));
    if (pick < 68) send_request(FN_OPEN, r, c);
    else if (pick < 86) send_request(FN_QUERY, r, c);
    else if (pick < 94) send_request(2'($urandom_range(1)), rr, rc);
    else if (pick < 97) send_request(FN_UNUSED, rr, rc);
    else if (pick < 98 && side <= 16) send_request(FN_CLEAR, rr, rc);
    else send_request(FN_QUERY, r, c);
  endtask

  initial begin
    logic [6:0] sizes [10];
    sizes = '{7'd4, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd127, 7'd0, 7'd64, 7'd6};
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed requests on the reset-size grid: corners, both virtual rows, every
    // function code, reopening, and coordinates just outside and far outside.
    send_request(FN_OPEN, 7'd1, 7'd1);
    send_request(FN_OPEN, 7'd1, 7'd1);
    send_request(FN_OPEN, 7'd64, 7'd64);
    send_request(FN_OPEN, 7'd1, 7'd64);
    send_request(FN_OPEN, 7'd2, 7'd1);
    send_request(FN_QUERY, 7'd2, 7'd1);
    send_request(FN_QUERY, 7'd64, 7'd1);
    send_request(FN_OPEN, 7'd0, 7'd5);
    send_request(FN_OPEN, 7'd5, 7'd0);
    send_request(FN_QUERY, 7'd65, 7'd1);
    send_request(FN_QUERY, 7'd1, 7'd65);
    send_request(FN_OPEN, 7'd127, 7'd127);
    send_request(FN_UNUSED, 7'd3, 7'd3);
    send_request(FN_CLEAR, 7'd9, 7'd9);
    send_request(FN_QUERY, 7'd1, 7'd1);

    // A single-row grid must percolate from the first open site.
    write_grid_size(7'd1);
    send_request(FN_QUERY, 7'd1, 7'd1);
    send_request(FN_OPEN, 7'd1, 7'd1);
    send_request(FN_OPEN, 7'd1, 7'd2);
    send_request(FN_QUERY, 7'd1, 7'd1);

    for (int ph = 0; ph < 10; ph++) begin
      tx_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 75 : 0;
      rx_idle_pct = (ph < 3) ? 75 : (ph < 6) ? 16 : 0;
      write_grid_size(sizes[ph]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i == RANDOM_PER_PHASE / 2) drain_results();
        random_request();
      end
    end

    drain_results();
    $display("covered %0d requests, %0d results, %0d grid size writes", items_sent,
             result_count, cfg_writes);
    $display("grid sizes 1 to 64 with clamped values, stalls on both sides, %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
